### sv/max_tracking_fifo_top_defines.svh
// Assertion macros shared by the max-tracking FIFO modules.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef MAX_TRACKING_FIFO_TOP_DEFINES_SVH
`define MAX_TRACKING_FIFO_TOP_DEFINES_SVH

`define MTF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define MTF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mtf_pkg.sv
// Types and codes for the max-tracking FIFO.
// No dependencies; imported by every module of the block.
package mtf_pkg;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] value_in;
	} mtf_in_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic signed [31:0] max_value;
		logic               max_valid;
		logic [1:0]         status;
	} mtf_out_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_XFER_WR,
		S_XFER_RD,
		S_POP_RD,
		S_POP_VAL,
		S_POP_WAIT,
		S_POP_MAX,
		S_REPORT
	} mtf_state_t;

endpackage

### sv/max_tracking_fifo_top.sv
// Max-tracking FIFO of signed words built from two stacks in synchronous memories.
// An enqueue or failed dequeue strobes done in the cycle after start is taken; a new start
// is taken only while idle. A dequeue refills an empty output stack, then pops it.
// Each stack has a single registered read port; a move alternates write and read states.
// The receiver cannot stall: done marks each result for one cycle; arst_n empties both stacks.
module max_tracking_fifo_top
	import mtf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int WORD_WIDTH  = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  mtf_in_t  item,
	output logic     busy,
	output logic     done,
	output mtf_out_t result
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;

	logic [WORD_WIDTH-1:0] word_in;
	logic [CW-1:0]         in_cnt;
	logic [CW-1:0]         out_cnt;
	logic [WORD_WIDTH-1:0] in_rd_val;
	logic [WORD_WIDTH-1:0] in_rd_max;
	logic [WORD_WIDTH-1:0] out_rd_val;
	logic [WORD_WIDTH-1:0] out_rd_max;
	logic [WORD_WIDTH-1:0] in_push_max;
	logic [WORD_WIDTH-1:0] out_push_max;
	logic [WORD_WIDTH-1:0] value_w;
	logic [WORD_WIDTH-1:0] max_w;
	logic                  max_valid;
	logic [1:0]            status;
	stack_cmd_t            in_cmd;
	stack_cmd_t            out_cmd;

	assign word_in = WORD_WIDTH'(item.value_in[IW-1:0]);

	mtf_ctrl #(
		.DEPTH(QUEUE_DEPTH),
		.W    (WORD_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (item.operation),
		.word_in     (word_in),
		.in_cnt      (in_cnt),
		.out_cnt     (out_cnt),
		.in_rd_val   (in_rd_val),
		.in_rd_max   (in_rd_max),
		.out_rd_val  (out_rd_val),
		.out_rd_max  (out_rd_max),
		.in_cmd      (in_cmd),
		.out_cmd     (out_cmd),
		.in_push_max (in_push_max),
		.out_push_max(out_push_max),
		.busy        (busy),
		.done        (done),
		.value_out   (value_w),
		.max_value   (max_w),
		.max_valid   (max_valid),
		.status      (status)
	);

	mtf_stack #(
		.DEPTH(QUEUE_DEPTH),
		.W    (WORD_WIDTH)
	) u_in_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (in_cmd),
		.push_val(word_in),
		.push_max(in_push_max),
		.cnt     (in_cnt),
		.rd_val  (in_rd_val),
		.rd_max  (in_rd_max)
	);

	mtf_stack #(
		.DEPTH(QUEUE_DEPTH),
		.W    (WORD_WIDTH)
	) u_out_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (out_cmd),
		.push_val(in_rd_val),
		.push_max(out_push_max),
		.cnt     (out_cnt),
		.rd_val  (out_rd_val),
		.rd_max  (out_rd_max)
	);

	generate
		if (WORD_WIDTH >= 32) begin : g_trunc
			assign result.value_out = value_w[31:0];
			assign result.max_value = max_w[31:0];
		end else begin : g_sext
			assign result.value_out = 32'($signed(value_w));
			assign result.max_value = 32'($signed(max_w));
		end
	endgenerate

	assign result.max_valid = max_valid;
	assign result.status    = status;

endmodule

### sv/mtf_stack.sv
// One stack of the FIFO: synchronous memory of {max, value} words and its fill count.
// The read port is registered and fetches the current top entry (address 0 when empty).
// Depends on mtf_pkg and max_tracking_fifo_top_defines.svh.
`include "max_tracking_fifo_top_defines.svh"

module mtf_stack
	import mtf_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int W     = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  stack_cmd_t                 cmd,
	input  logic [W-1:0]               push_val,
	input  logic [W-1:0]               push_max,
	output logic [$clog2(DEPTH+1)-1:0] cnt,
	output logic [W-1:0]               rd_val,
	output logic [W-1:0]               rd_max
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  cnt_dec;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic [2*W-1:0] mem [DEPTH];
	logic [2*W-1:0] rd_q;

	assign cnt_dec = cnt_q - CW'(1);
	assign rd_addr = (cnt_q == '0) ? '0 : cnt_dec[AW-1:0];
	assign wr_addr = cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.pop) begin
			cnt_q <= cnt_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= {push_max, push_val};
		end
		rd_q <= mem[rd_addr];
	end

	assign cnt    = cnt_q;
	assign rd_val = rd_q[W-1:0];
	assign rd_max = rd_q[2*W-1:W];

	`MTF_ASSERT_NOW(a_single_cmd, cmd.push, !cmd.pop, "stack push and pop together")
	`MTF_ASSERT_NOW(a_no_overflow, cmd.push, cnt_q < CW'(DEPTH), "push onto full stack")
	`MTF_ASSERT_NOW(a_no_underflow, cmd.pop, cnt_q != '0, "pop from empty stack")
	`MTF_ASSERT_NEXT(a_push_count, cmd.push, cnt_q == $past(cnt_q) + CW'(1), "count lost a push")

endmodule

### sv/mtf_ctrl.sv
// Sequencer of the FIFO: enqueue, stack transfer, dequeue and result report.
// Tracks the stack-top maxima and drives both stacks through command structs.
// Depends on mtf_pkg and max_tracking_fifo_top_defines.svh.
`include "max_tracking_fifo_top_defines.svh"

module mtf_ctrl
	import mtf_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int W     = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       op,
	input  logic [W-1:0]               word_in,
	input  logic [$clog2(DEPTH+1)-1:0] in_cnt,
	input  logic [$clog2(DEPTH+1)-1:0] out_cnt,
	input  logic [W-1:0]               in_rd_val,
	input  logic [W-1:0]               in_rd_max,
	input  logic [W-1:0]               out_rd_val,
	input  logic [W-1:0]               out_rd_max,
	output stack_cmd_t                 in_cmd,
	output stack_cmd_t                 out_cmd,
	output logic [W-1:0]               in_push_max,
	output logic [W-1:0]               out_push_max,
	output logic                       busy,
	output logic                       done,
	output logic [W-1:0]               value_out,
	output logic [W-1:0]               max_value,
	output logic                       max_valid,
	output logic [1:0]                 status
);

	localparam int CW = $clog2(DEPTH + 1);

	mtf_state_t    state_q;
	mtf_state_t    state_d;
	logic [W-1:0]  in_top_max_q;
	logic [W-1:0]  out_top_max_q;
	logic [W-1:0]  value_q;
	logic [1:0]    status_q;
	logic [CW:0]   total;
	logic          full;
	logic          in_nonempty;
	logic          out_nonempty;
	logic          accept;

	assign total        = {1'b0, in_cnt} + {1'b0, out_cnt};
	assign full         = total >= (CW+1)'(DEPTH);
	assign in_nonempty  = in_cnt != '0;
	assign out_nonempty = out_cnt != '0;
	assign accept       = start && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (op == OP_ENQ) begin
						state_d = S_REPORT;
					end else if (out_nonempty) begin
						state_d = S_POP_VAL;
					end else if (in_nonempty) begin
						state_d = S_XFER_WR;
					end else begin
						state_d = S_REPORT;
					end
				end
			end
			S_XFER_WR: begin
				state_d = (in_cnt == CW'(1)) ? S_POP_RD : S_XFER_RD;
			end
			S_XFER_RD:  state_d = S_XFER_WR;
			S_POP_RD:   state_d = S_POP_VAL;
			S_POP_VAL: begin
				state_d = (out_cnt == CW'(1)) ? S_REPORT : S_POP_WAIT;
			end
			S_POP_WAIT: state_d = S_POP_MAX;
			S_POP_MAX:  state_d = S_REPORT;
			S_REPORT:   state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_cmd.push  = accept && (op == OP_ENQ) && !full;
		in_cmd.pop   = state_q == S_XFER_WR;
		out_cmd.push = state_q == S_XFER_WR;
		out_cmd.pop  = state_q == S_POP_VAL;
		busy         = state_q != S_IDLE;
		done         = state_q == S_REPORT;

		in_push_max = word_in;
		if (in_nonempty && !($signed(word_in) >= $signed(in_rd_max))) begin
			in_push_max = in_rd_max;
		end
		out_push_max = in_rd_val;
		if (out_nonempty && !($signed(in_rd_val) >= $signed(out_top_max_q))) begin
			out_push_max = out_top_max_q;
		end

		value_out = value_q;
		status    = status_q;
		max_valid = in_nonempty || out_nonempty;
		max_value = '0;
		if (in_nonempty && out_nonempty) begin
			max_value = ($signed(in_top_max_q) >= $signed(out_top_max_q)) ?
				in_top_max_q : out_top_max_q;
		end else if (in_nonempty) begin
			max_value = in_top_max_q;
		end else if (out_nonempty) begin
			max_value = out_top_max_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= '0;
			if (op == OP_ENQ) begin
				status_q <= full ? STAT_FULL : STAT_OK;
			end else begin
				status_q <= (in_nonempty || out_nonempty) ? STAT_OK : STAT_EMPTY;
			end
		end
		if (in_cmd.push) begin
			in_top_max_q <= in_push_max;
		end
		if (out_cmd.push) begin
			out_top_max_q <= out_push_max;
		end
		if (state_q == S_POP_VAL) begin
			value_q <= out_rd_val;
		end
		if (state_q == S_POP_MAX) begin
			out_top_max_q <= out_rd_max;
		end
	end

	`MTF_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`MTF_ASSERT_NEXT(a_empty_deq, accept && op == OP_DEQ && !in_nonempty && !out_nonempty, done && status == STAT_EMPTY, "empty dequeue not reported")
	`MTF_ASSERT_NEXT(a_full_hold, accept && op == OP_ENQ && full, in_cnt == $past(in_cnt) && out_cnt == $past(out_cnt), "full enqueue changed the queue")
	`MTF_ASSERT_NOW(a_pop_nonempty, state_q == S_POP_VAL, out_nonempty, "pop state with empty output stack")

endmodule
